[hw/rtl/ipsl_pkg.sv]
// Package for the incremental PI speed loop: widths, codes, register map and types.
// Used by the channel interfaces, the register block, the core and the top level.
// Has no dependencies of its own.
package ipsl_pkg;

	// Field and datapath widths.
	localparam int SpeedW = 16;
	localparam int GainW  = 16;
	localparam int ErrW   = SpeedW + 1;
	localparam int DeltaW = ErrW + 1;
	localparam int DriveW = 11;
	localparam int FracW  = 12;
	localparam int ProdCW = GainW + 1 + DeltaW;
	localparam int ProdEW = GainW + 1 + ErrW;
	localparam int SumW   = ProdCW + 2;
	localparam int QuotW  = SumW - FracW;

	// Configuration port geometry.
	localparam int DataW = 32;
	localparam int AddrW = 3;

	// Register indexes, taken from paddr[2].
	localparam logic RegErrorGain  = 1'b0;
	localparam logic RegChangeGain = 1'b1;

	typedef logic signed [SpeedW-1:0] speed_t;
	typedef logic signed [ErrW-1:0]   err_t;
	typedef logic signed [DriveW-1:0] drive_t;
	typedef logic [GainW-1:0]         gain_t;

	// Register reset values: 0.6 and 0.3 in unsigned Q4.12.
	localparam gain_t ErrorGainReset  = gain_t'(2458);
	localparam gain_t ChangeGainReset = gain_t'(1229);

	// Output saturation limits.
	localparam drive_t DriveMax = drive_t'(999);
	localparam drive_t DriveMin = drive_t'(-999);

	// Request operation codes.
	typedef enum logic {
		OpStep  = 1'b0,
		OpClear = 1'b1
	} op_t;

	// Gains handed from the register block to the core.
	typedef struct packed {
		gain_t error_gain;
		gain_t change_gain;
	} gains_t;

endpackage

[hw/rtl/ipsl_step_if.sv]
// Input channel of the speed loop: one request is a step or a clear with two speeds.
// Depends on ipsl_pkg for the payload types.
interface ipsl_step_if;
	logic            valid;
	logic            ready;
	ipsl_pkg::op_t    operation;
	ipsl_pkg::speed_t target_speed;
	ipsl_pkg::speed_t measured_speed;

	modport source (output valid, output operation, output target_speed,
		output measured_speed, input ready);
	modport sink (input valid, input operation, input target_speed,
		input measured_speed, output ready);
endinterface

[hw/rtl/ipsl_drive_if.sv]
// Output channel of the speed loop: one request carries the clamped drive value.
// Depends on ipsl_pkg for the payload type.
interface ipsl_drive_if;
	logic             valid;
	logic             ready;
	ipsl_pkg::drive_t drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

[hw/rtl/ipsl_regs.sv]
// APB-style register block holding the two loop gains.
// Depends on ipsl_pkg for the register map and the gains struct.
module ipsl_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipsl_pkg::AddrW-1:0]   paddr,
	input  logic [ipsl_pkg::DataW-1:0]   pwdata,
	output logic [ipsl_pkg::DataW-1:0]   prdata,
	output logic                         pready,
	output ipsl_pkg::gains_t             gains
);
	import ipsl_pkg::*;

	gain_t error_gain_q;
	gain_t change_gain_q;
	logic  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes; the byte offset within a word is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_gain_q  <= ErrorGainReset;
			change_gain_q <= ChangeGainReset;
		end else if (wr_en) begin
			unique case (paddr[2])
				RegErrorGain:  error_gain_q  <= pwdata[GainW-1:0];
				RegChangeGain: change_gain_q <= pwdata[GainW-1:0];
				default: ;
			endcase
		end
	end

	// Read data follows the addressed register.
	always_comb begin
		unique case (paddr[2])
			RegErrorGain:  prdata = DataW'(error_gain_q);
			RegChangeGain: prdata = DataW'(change_gain_q);
			default:       prdata = '0;
		endcase
	end

	assign gains.error_gain  = error_gain_q;
	assign gains.change_gain = change_gain_q;
endmodule

[hw/rtl/ipsl_core.sv]
// Core of the speed loop: input register, combinational PI update with state, result register.
// Depends on ipsl_pkg and the two channel interfaces.
module ipsl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ipsl_pkg::gains_t gains,
	ipsl_step_if.sink        step,
	ipsl_drive_if.source     result
);
	import ipsl_pkg::*;

	// Input stage.
	logic   valid_s1;
	op_t    op_s1;
	speed_t target_s1;
	speed_t measured_s1;

	// Loop state.
	drive_t control_q;
	err_t   prev_err_q;

	// Result stage.
	logic   valid_s2;
	drive_t drive_s2;

	// Update datapath.
	err_t                     err;
	logic signed [DeltaW-1:0] delta;
	logic signed [ProdCW-1:0] prod_c;
	logic signed [ProdEW-1:0] prod_e;
	logic signed [SumW-1:0]   sum;
	logic signed [QuotW-1:0]  quot;
	drive_t                   next_control;
	err_t                     next_err;
	logic                     advance;

	localparam logic signed [QuotW-1:0] QuotMax = QuotW'(DriveMax);
	localparam logic signed [QuotW-1:0] QuotMin = QuotW'(DriveMin);

	// The input stage moves on whenever the result stage is empty or being drained.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign step.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			op_s1       <= step.operation;
			target_s1   <= step.target_speed;
			measured_s1 <= step.measured_speed;
		end
	end

	// Error, its change, and the two gain products.
	always_comb begin
		err    = ErrW'(target_s1) - ErrW'(measured_s1);
		delta  = DeltaW'(err) - DeltaW'(prev_err_q);
		prod_c = $signed({1'b0, gains.change_gain}) * delta;
		prod_e = $signed({1'b0, gains.error_gain}) * err;
		sum    = (SumW'(control_q) <<< FracW) + SumW'(prod_c) + SumW'(prod_e);
	end

	// Scale down with truncation toward zero, then saturate; a clear forces both state values to zero.
	always_comb begin
		quot = QuotW'(sum >>> FracW);
		if (sum[SumW-1] && (sum[FracW-1:0] != '0)) begin
			quot = quot + QuotW'(1);
		end
		if (quot > QuotMax) begin
			next_control = DriveMax;
		end else if (quot < QuotMin) begin
			next_control = DriveMin;
		end else begin
			next_control = DriveW'(quot);
		end
		next_err = err;
		if (op_s1 == OpClear) begin
			next_control = '0;
			next_err     = '0;
		end
	end

	// State and result update, one item per cycle while the result stage is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= '0;
			prev_err_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (advance) begin
				control_q  <= next_control;
				prev_err_q <= next_err;
				valid_s2   <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= next_control;
		end
	end

	assign result.valid = valid_s2;
	assign result.drive = drive_s2;
endmodule

[hw/rtl/incremental_pi_speed_loop_top.sv]
// Top level of the incremental PI speed loop for one motor channel.
// Depends on ipsl_pkg, ipsl_step_if, ipsl_drive_if, ipsl_regs and ipsl_core.
//
//   channel  direction  handshake        payload
//   step     in         valid/ready      operation, target_speed, measured_speed
//   result   out        valid/ready      drive
//   apb      in         psel/penable     error_gain at 0x0, change_gain at 0x4
//
// A request is taken into the input register and its drive value then lands in the output
// register once that register is free or being drained; one request can be taken every
// cycle while the result is not stalled.
// The PI update, its two gain multiplies and the clamp are combinational between the two
// registers, as the control value and previous error feed back into the next request.
// Reset clears both state values and loads the default gains; no clearing pass.
// A stalled result holds in the output register while the input register still fills.
module incremental_pi_speed_loop_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ipsl_pkg::AddrW-1:0] paddr,
	input  logic [ipsl_pkg::DataW-1:0] pwdata,
	output logic [ipsl_pkg::DataW-1:0] prdata,
	output logic                       pready,
	ipsl_step_if.sink                  step,
	ipsl_drive_if.source               result
);
	import ipsl_pkg::*;

	gains_t gains;

	// Gain registers.
	ipsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// Control datapath.
	ipsl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.gains  (gains),
		.step   (step),
		.result (result)
	);
endmodule

[hw/rtl/ipsl_checker.sv]
// Port-level checks for the incremental PI speed loop, bound to the top level.
// Depends on ipsl_pkg for widths and limits.
module ipsl_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic                       pready,
	input logic [ipsl_pkg::AddrW-1:0] paddr,
	input logic [ipsl_pkg::DataW-1:0] pwdata,
	input logic [ipsl_pkg::DataW-1:0] prdata,
	input logic                       step_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input ipsl_pkg::drive_t           drive
);
	import ipsl_pkg::*;

	// The configuration port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A written gain reads back on the next cycle from the same register.
	a_write_readback: assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(psel && penable && pwrite) && (paddr[2] == $past(paddr[2])))
		|-> (prdata == DataW'($past(pwdata[GainW-1:0]))))
		else $error("gain register read-back mismatch");

	// Results always lie inside the saturation limits.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((drive <= DriveMax) && (drive >= DriveMin)))
		else $error("drive outside limits");

	// With the output register empty, the block must take a new request.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> step_ready)
		else $error("step stalled with empty output");

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(drive)))
		else $error("stalled result changed");
endmodule

bind incremental_pi_speed_loop_top ipsl_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.pready       (pready),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.step_ready   (step.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.drive        (result.drive)
);

[test/incremental_pi_speed_loop_top_test.sv]
// Self-checking bench for incremental_pi_speed_loop_top: random and directed speed requests,
// a cycle-free PI predictor, gain sweeps over the APB port and random stalls on both channels.
// Depends on ipsl_pkg, ipsl_step_if, ipsl_drive_if and the top level of the speed loop.
module incremental_pi_speed_loop_top_test;
	import ipsl_pkg::*;

	localparam int     StallLimit = 5000;
	localparam int     PhaseReqs  = 86;
	localparam int     GainPhases = 7;
	localparam longint GainOne    = longint'(1) << FracW;

	typedef struct {
		op_t    op;
		speed_t target;
		speed_t measured;
	} step_req_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;

	ipsl_step_if  step_ch ();
	ipsl_drive_if drive_ch ();

	// Requests waiting for the driver and drive values waiting for the monitor.
	step_req_t pending_reqs[$];
	drive_t    drive_expect[$];
	step_req_t next_req;

	// Predictor state and the gains it believes are loaded.
	drive_t ctrl_value = '0;
	err_t   last_error = '0;
	gain_t  error_gain_q;
	gain_t  change_gain_q;

	int  reqs_queued;
	int  drives_seen;
	int  fault_count;
	int  stall_cycles;
	bit  steady;

	gain_t eg_plan[GainPhases] = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd2458};
	gain_t cg_plan[GainPhases] = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd1229};

	incremental_pi_speed_loop_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.step    (step_ch),
		.result  (drive_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Print the first few faults in full; count the rest.
	task automatic flag_fault(input string what);
		if (fault_count < 10) begin
			$display("MISMATCH: %s", what);
		end
		fault_count++;
	endtask

	// PI update: exact sum in Q.12, one truncation toward zero, then the clamp; a clear zeroes the state.
	function automatic drive_t next_drive(op_t op, speed_t target, speed_t measured);
		longint err;
		longint acc;
		longint quot;
		if (op == OpClear) begin
			ctrl_value = '0;
			last_error = '0;
		end else begin
			err  = longint'(target) - longint'(measured);
			acc  = longint'(ctrl_value) * GainOne
				+ longint'(change_gain_q) * (err - longint'(last_error))
				+ longint'(error_gain_q) * err;
			quot = acc / GainOne;
			if (quot > longint'(DriveMax)) begin
				quot = longint'(DriveMax);
			end else if (quot < longint'(DriveMin)) begin
				quot = longint'(DriveMin);
			end
			ctrl_value = drive_t'(quot);
			last_error = err_t'(err);
		end
		return ctrl_value;
	endfunction

	function automatic void queue_req(op_t op, speed_t target, speed_t measured);
		step_req_t r;
		r.op       = op;
		r.target   = target;
		r.measured = measured;
		pending_reqs.push_back(r);
		reqs_queued++;
	endfunction

	// Mostly tracking requests near a set point, some with full-range speeds, some clears.
	function automatic void queue_random_req();
		int unsigned pick;
		int          base;
		int          delta;
		pick = $urandom_range(99);
		base = int'($urandom_range(40000)) - 20000;
		if (pick < 10) begin
			queue_req(OpClear, speed_t'($urandom), speed_t'($urandom));
		end else if (pick < 45) begin
			delta = int'($urandom_range(40)) - 20;
			queue_req(OpStep, speed_t'(base), speed_t'(base - delta));
		end else if (pick < 75) begin
			delta = int'($urandom_range(600)) - 300;
			queue_req(OpStep, speed_t'(base), speed_t'(base - delta));
		end else begin
			queue_req(OpStep, speed_t'($urandom), speed_t'($urandom));
		end
	endfunction

	// One APB transfer: setup cycle, then access until pready.
	task automatic apb_access(input logic wr, input logic idx, input logic [DataW-1:0] wdata,
		output logic [DataW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= AddrW'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		rdata = prdata;
		if (wr && idx == RegErrorGain) begin
			error_gain_q = wdata[GainW-1:0];
		end else if (wr && idx == RegChangeGain) begin
			change_gain_q = wdata[GainW-1:0];
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Load both gains and read them back.
	task automatic set_gains(input gain_t eg, input gain_t cg);
		logic [DataW-1:0] rd;
		apb_access(1'b1, RegErrorGain, DataW'(eg), rd);
		apb_access(1'b1, RegChangeGain, DataW'(cg), rd);
		apb_access(1'b0, RegErrorGain, '0, rd);
		if (rd[GainW-1:0] !== eg) begin
			flag_fault($sformatf("error_gain read back: expected %0d, got %0d", eg, rd));
		end
		apb_access(1'b0, RegChangeGain, '0, rd);
		if (rd[GainW-1:0] !== cg) begin
			flag_fault($sformatf("change_gain read back: expected %0d, got %0d", cg, rd));
		end
	endtask

	// Hold the sender back until every queued request has produced its drive value.
	task automatic wait_drained();
		while (drives_seen != reqs_queued) begin
			@(posedge clk);
		end
	endtask

	// Step channel driver: predict on acceptance, then offer the next request or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ch.valid          <= 1'b0;
			step_ch.operation      <= OpStep;
			step_ch.target_speed   <= '0;
			step_ch.measured_speed <= '0;
		end else begin
			if (step_ch.valid && step_ch.ready) begin
				drive_expect.push_back(next_drive(step_ch.operation, step_ch.target_speed,
					step_ch.measured_speed));
			end
			if (!step_ch.valid || step_ch.ready) begin
				if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
					next_req = pending_reqs.pop_front();
					step_ch.valid          <= 1'b1;
					step_ch.operation      <= next_req.op;
					step_ch.target_speed   <= next_req.target;
					step_ch.measured_speed <= next_req.measured;
				end else begin
					step_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result channel monitor: random back-pressure and an in-order compare.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_ch.ready <= 1'b0;
		end else begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (drive_expect.size() == 0) begin
					flag_fault($sformatf("drive %0d with no request outstanding", drive_ch.drive));
				end else begin
					if (drive_ch.drive !== drive_expect[0]) begin
						flag_fault($sformatf("drive: expected %0d, got %0d", drive_expect[0],
							drive_ch.drive));
					end
					void'(drive_expect.pop_front());
					drives_seen++;
				end
			end
			drive_ch.ready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog on cycles in which no channel moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((step_ch.valid && step_ch.ready) || (drive_ch.valid && drive_ch.ready)
				|| (psel && penable)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= StallLimit) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		arst_n                  = 1'b0;
		steady                  = 1'b0;
		reqs_queued             = 0;
		error_gain_q            = ErrorGainReset;
		change_gain_q           = ChangeGainReset;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset gains: extremes, saturation, truncation, clears.
		queue_req(OpClear, speed_t'(32767), speed_t'(-32768));
		queue_req(OpStep, speed_t'(32767), speed_t'(-32768));
		queue_req(OpStep, speed_t'(32767), speed_t'(-32768));
		queue_req(OpStep, speed_t'(-32768), speed_t'(32767));
		queue_req(OpStep, speed_t'(0), speed_t'(0));
		queue_req(OpStep, speed_t'(-32768), speed_t'(-32768));
		queue_req(OpStep, speed_t'(32767), speed_t'(32767));
		queue_req(OpClear, 16'h5555, 16'hAAAA);
		queue_req(OpStep, speed_t'(1), speed_t'(0));
		queue_req(OpStep, speed_t'(-1), speed_t'(0));
		queue_req(OpStep, speed_t'(0), speed_t'(1));
		queue_req(OpStep, speed_t'(100), speed_t'(90));
		queue_req(OpStep, speed_t'(120), speed_t'(100));
		queue_req(OpStep, speed_t'(-50), speed_t'(40));
		queue_req(OpStep, 16'h5555, 16'h2AAA);
		queue_req(OpStep, speed_t'(-32768), speed_t'(0));
		queue_req(OpStep, speed_t'(0), speed_t'(-32768));
		queue_req(OpClear, speed_t'(-1), speed_t'(-1));
		queue_req(OpStep, 16'hAAAA, 16'h5555);
		queue_req(OpStep, speed_t'(3), speed_t'(7));
		wait_drained();

		// Random requests under a sweep of gain settings, one phase without stalls.
		for (int p = 0; p < GainPhases; p++) begin
			if (p == 4) begin
				eg_plan[p] = gain_t'($urandom);
				cg_plan[p] = gain_t'($urandom);
			end else if (p == 5) begin
				eg_plan[p] = gain_t'($urandom_range(8191));
				cg_plan[p] = gain_t'($urandom_range(8191));
			end
			set_gains(eg_plan[p], cg_plan[p]);
			steady = (p == 5);
			for (int i = 0; i < PhaseReqs; i++) begin
				queue_random_req();
			end
			wait_drained();
		end
		steady = 1'b0;

		repeat (8) @(posedge clk);
		if (fault_count == 0 && drive_expect.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/ipsl_pkg.sv
hw/rtl/ipsl_step_if.sv
hw/rtl/ipsl_drive_if.sv
hw/rtl/ipsl_regs.sv
hw/rtl/ipsl_core.sv
hw/rtl/incremental_pi_speed_loop_top.sv
hw/rtl/ipsl_checker.sv
test/incremental_pi_speed_loop_top_test.sv
